@@ design/gpio_output_with_pulse_timers_core_assert.svh @@
// assertion macros for the gpio output core
// used by the top level; expects aclk and aresetn in scope
`ifndef GPIO_OUTPUT_WITH_PULSE_TIMERS_CORE_ASSERT_SVH
`define GPIO_OUTPUT_WITH_PULSE_TIMERS_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// implication checked on every clock edge outside reset
`define GPO_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gpo assertion failed");
// consequence checked in the cycle after the antecedent
`define GPO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gpo assertion failed");
`else
`define GPO_ASSERT_IMPL(lbl, ante, cons)
`define GPO_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/gpo_pkg.sv @@
// shared types and constants for the gpio output core
// no dependencies
package gpo_pkg;

    // port and counter widths
    localparam int PORT_W     = 16;
    localparam int PIN_CNT_W  = 5;
    localparam int CNT_W      = 17;
    localparam int DEF_NUM_PINS = 16;

    // stream word widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;

    // action codes; six and seven do nothing
    typedef enum logic [2:0] {
        ACT_WRITE  = 3'd0,
        ACT_SET    = 3'd1,
        ACT_CLEAR  = 3'd2,
        ACT_TOGGLE = 3'd3,
        ACT_PULSE  = 3'd4,
        ACT_TICK   = 3'd5
    } action_t;

    // command broadcast to every pin cell
    typedef struct packed {
        logic                fire;
        action_t             action;
        logic                pol;
        logic [CNT_W-1:0]    load_val;
    } pin_cmd_t;

endpackage

@@ design/gpo_spread.sv @@
// deposits packed bits onto enabled pins and counts enabled pins
// depends on gpo_pkg
module gpo_spread #(
    parameter int NUM_PINS = gpo_pkg::DEF_NUM_PINS
) (
    input  logic [NUM_PINS-1:0]          mask,
    input  logic [gpo_pkg::PORT_W-1:0]   packed_value,
    output logic [NUM_PINS-1:0]          spread,
    output logic [gpo_pkg::PIN_CNT_W-1:0] pin_count
);
    import gpo_pkg::*;

    // per pin: rank among enabled pins below it selects the packed bit
    always_comb begin
        logic [PIN_CNT_W-1:0] rank;
        for (int i = 0; i < NUM_PINS; i++) begin
            rank = '0;
            for (int j = 0; j < i; j++) begin
                rank = rank + PIN_CNT_W'(mask[j]);
            end
            spread[i] = mask[i] && (rank < PIN_CNT_W'(PORT_W))
                        && packed_value[rank[$clog2(PORT_W)-1:0]];
        end
    end

    // enabled pin count
    always_comb begin
        pin_count = '0;
        for (int i = 0; i < NUM_PINS; i++) begin
            pin_count = pin_count + PIN_CNT_W'(mask[i]);
        end
    end

endmodule

@@ design/gpo_pin_cell.sv @@
// one output pin: level, pulse counter and queued levels
// depends on gpo_pkg
module gpo_pin_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  gpo_pkg::pin_cmd_t cmd,
    input  logic              spread_bit,
    input  logic              mask_bit,
    output logic              level,
    output logic              busy,
    output logic              level_next,
    output logic              busy_next
);
    import gpo_pkg::*;

    logic             level_reg, level_nx;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ph_reg, ph_next;
    logic             pl_reg, pl_next;

    // next state for the current command
    always_comb begin
        level_nx = level_reg;
        cnt_next = cnt_reg;
        ph_next  = ph_reg;
        pl_next  = pl_reg;
        if (cmd.fire) begin
            unique case (cmd.action)
                ACT_WRITE: begin
                    if (spread_bit) cnt_next = '0;
                    if (mask_bit) level_nx = spread_bit;
                end
                ACT_SET: begin
                    if (spread_bit) begin
                        cnt_next = '0;
                        level_nx = 1'b1;
                    end
                end
                ACT_CLEAR: begin
                    if (spread_bit) begin
                        cnt_next = '0;
                        level_nx = 1'b0;
                    end
                end
                ACT_TOGGLE: begin
                    if (spread_bit) begin
                        cnt_next = '0;
                        level_nx = ~level_reg;
                    end
                end
                ACT_PULSE: begin
                    if (spread_bit) begin
                        cnt_next = cmd.load_val;
                        if (cmd.pol) ph_next = 1'b1;
                        else         pl_next = 1'b1;
                    end
                end
                ACT_TICK: begin
                    // queued high wins over queued low
                    if (ph_reg)      level_nx = 1'b1;
                    else if (pl_reg) level_nx = 1'b0;
                    if (cnt_reg != '0) begin
                        cnt_next = cnt_reg - CNT_W'(1);
                        if (cnt_reg == CNT_W'(1)) level_nx = ~level_nx;
                    end
                    ph_next = 1'b0;
                    pl_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 1'b0;
            cnt_reg   <= '0;
            ph_reg    <= 1'b0;
            pl_reg    <= 1'b0;
        end else begin
            level_reg <= level_nx;
            cnt_reg   <= cnt_next;
            ph_reg    <= ph_next;
            pl_reg    <= pl_next;
        end
    end

    assign level      = level_reg;
    assign busy       = (cnt_reg != '0) || ph_reg || pl_reg;
    assign level_next = level_nx;
    assign busy_next  = (cnt_next != '0) || ph_next || pl_next;

endmodule

@@ design/gpio_output_with_pulse_timers_core.sv @@
// top level of the gpio output core with per-pin pulse timers
// depends on gpo_pkg, gpo_spread, gpo_pin_cell and the assertion header
//
// Usage:
//   s_ channel: one command word per handshake. s_tuser carries the action
//   (write, set, clear, toggle, pulse, tick). s_tdata carries
//   packed_value, pulse_polarity and pulse_length.
//   m_ channel: one result word per command with the pin levels after the
//   command, the busy flag and the number of enabled pins.
//   cfg channel: writes pin_mask; always ready, write only while idle.
// Timing:
//   a command is registered on accept and evaluated by the pin cells when it
//   advances out of the input register; its result word is then registered for m_.
//   One command per cycle is sustained while m_tready stays high; the pin cells update in parallel.
// Reset (aresetn low, synchronous): levels, counters, queued levels and
//   pin_mask clear, both stages empty.
// Stall: with m_tready low the result stays on m_tdata; one more command is
//   held in the input register, after which s_tready drops.
`include "gpio_output_with_pulse_timers_core_assert.svh"

module gpio_output_with_pulse_timers_core #(
    parameter int NUM_PINS = gpo_pkg::DEF_NUM_PINS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // command channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] packed_value, [16] pulse_polarity, [32:17] pulse_length, rest zero
    input  logic [gpo_pkg::S_TDATA_W-1:0]  s_tdata,
    // [2:0] action
    input  logic [gpo_pkg::S_TUSER_W-1:0]  s_tuser,
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] pin_levels, [16] busy_res, [21:17] pin_count, rest zero
    output logic [gpo_pkg::M_TDATA_W-1:0]  m_tdata,
    // pin_mask write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gpo_pkg::PORT_W-1:0]     cfg_data
);
    import gpo_pkg::*;

    logic [PORT_W-1:0]    pin_mask_reg;
    logic                 in_valid_reg;
    action_t              action_reg;
    logic [PORT_W-1:0]    packed_reg;
    logic                 pol_reg;
    logic [PORT_W-1:0]    len_reg;
    logic                 out_valid_reg;
    logic [PORT_W-1:0]    levels_reg;
    logic                 busy_reg;
    logic [PIN_CNT_W-1:0] count_reg;

    logic                 advance;
    logic [NUM_PINS-1:0]  mask_eff;
    logic [NUM_PINS-1:0]  spread;
    logic [PIN_CNT_W-1:0] pin_count;
    pin_cmd_t             cmd;
    logic [NUM_PINS-1:0]  cell_level, cell_busy, cell_level_nx, cell_busy_nx;
    logic [PORT_W-1:0]    levels_cur, levels_nx;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_mask_reg <= '0;
        end else if (cfg_valid) begin
            pin_mask_reg <= cfg_data;
        end
    end

    // handshake between stages
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            action_reg <= action_t'(s_tuser);
            packed_reg <= s_tdata[PORT_W-1:0];
            pol_reg    <= s_tdata[PORT_W];
            len_reg    <= s_tdata[2*PORT_W:PORT_W+1];
        end
    end

    // pins past the port width never belong to the unit
    for (genvar i = 0; i < NUM_PINS; i++) begin : g_mask
        if (i < PORT_W) begin : g_port
            assign mask_eff[i] = pin_mask_reg[i];
        end else begin : g_none
            assign mask_eff[i] = 1'b0;
        end
    end

    gpo_spread #(
        .NUM_PINS(NUM_PINS)
    ) u_spread (
        .mask(mask_eff),
        .packed_value(packed_reg),
        .spread(spread),
        .pin_count(pin_count)
    );

    // command to the pin cells
    assign cmd.fire     = advance;
    assign cmd.action   = action_reg;
    assign cmd.pol      = pol_reg;
    assign cmd.load_val = CNT_W'(len_reg) + CNT_W'(1);

    for (genvar i = 0; i < NUM_PINS; i++) begin : g_cell
        gpo_pin_cell u_cell (
            .aclk(aclk),
            .aresetn(aresetn),
            .cmd(cmd),
            .spread_bit(spread[i]),
            .mask_bit(mask_eff[i]),
            .level(cell_level[i]),
            .busy(cell_busy[i]),
            .level_next(cell_level_nx[i]),
            .busy_next(cell_busy_nx[i])
        );
    end

    // map cells onto the port width
    for (genvar j = 0; j < PORT_W; j++) begin : g_port
        if (j < NUM_PINS) begin : g_pin
            assign levels_nx[j]  = cell_level_nx[j];
            assign levels_cur[j] = cell_level[j];
        end else begin : g_zero
            assign levels_nx[j]  = 1'b0;
            assign levels_cur[j] = 1'b0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            levels_reg <= levels_nx;
            busy_reg   <= |cell_busy_nx;
            count_reg  <= pin_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - PORT_W - 1 - PIN_CNT_W)'(0),
                       count_reg, busy_reg, levels_reg};

    // checks
    `GPO_ASSERT_IMPL(a_stall_blocks, in_valid_reg && out_valid_reg && !m_tready, !s_tready)
    `GPO_ASSERT_NEXT(a_busy_tracks, advance, busy_reg == |cell_busy)
    `GPO_ASSERT_NEXT(a_levels_track, advance, levels_reg == levels_cur)
    `GPO_ASSERT_IMPL(a_count_range, out_valid_reg, count_reg <= PIN_CNT_W'(PORT_W))

endmodule
